FILE: rtl/edf_pkg.sv
package edf_pkg;

  localparam int MaxTasks  = 8;
  localparam int MaxJobs   = 16;
  localparam int TaskIdxW  = 3;
  localparam int JobIdxW   = 4;
  localparam int TaskNumW  = 4;
  localparam int TaskCntW  = TaskIdxW + 1;
  localparam int JobCntW   = JobIdxW + 1;
  localparam logic [16:0] NeverRelease = 17'h1FFFF;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL,
    ST_SCAN,
    ST_RUN,
    ST_OUT
  } edf_state_t;

  typedef struct packed {
    logic load;
    logic rel_clear;
    logic rel_step;
    logic scan_clear;
    logic scan_step;
    logic run;
    logic done_tick;
  } edf_cmd_t;

  typedef struct packed {
    logic rel_last;
    logic scan_last;
    logic done_now;
  } edf_sts_t;

endpackage

FILE: rtl/edf_periodic_task_scheduler_unit.sv
// channel | handshake            | payload
// in      | in_valid / in_stall  | operation, task_index, compute, deadline, period
// out     | out_valid / out_stall| slot_time, running_task, idle, done_res, job_overflow
// cfg     | APB psel/penable     | horizon at byte address 0
// A load is written when accepted. A tick runs MaxTasks release steps, MaxJobs scan steps,
// one run step and one result state. A tick at the horizon goes straight to the
// result state. Input is stalled until the result is taken.
// Synchronous active-low reset clears time, task and job valid bits; horizon 65535.
module edf_periodic_task_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [2:0]  in_task_index,
  input  logic [15:0] in_compute_time,
  input  logic [15:0] in_relative_deadline,
  input  logic [15:0] in_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_slot_time,
  output logic [3:0]  out_running_task,
  output logic        out_idle,
  output logic        out_done_res,
  output logic        out_job_overflow,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import edf_pkg::*;

  edf_cmd_t    cmd;
  edf_sts_t    sts;
  logic [15:0] horizon_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {16'd0, horizon_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) horizon_r <= 16'hFFFF;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      horizon_r <= cfg_pwdata[15:0];
  end

  edf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation,
    .out_valid, .out_stall, .sts, .cmd
  );

  edf_dp u_dp (
    .clk, .rst_n, .in_task_index, .in_compute_time, .in_relative_deadline,
    .in_period, .horizon(horizon_r), .cmd, .sts, .out_slot_time,
    .out_running_task, .out_idle, .out_done_res, .out_job_overflow
  );

endmodule

FILE: rtl/edf_ctrl.sv
module edf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  output logic              out_valid,
  input  logic              out_stall,
  input  edf_pkg::edf_sts_t sts,
  output edf_pkg::edf_cmd_t cmd
);
  import edf_pkg::*;

  edf_state_t state_r, state_nxt;
  logic       acc;

  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_operation == OpTick) begin
          state_nxt = sts.done_now ? ST_OUT : ST_REL;
        end
      end
      ST_REL:  if (sts.rel_last) state_nxt = ST_SCAN;
      ST_SCAN: if (sts.scan_last) state_nxt = ST_RUN;
      ST_RUN:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load       = acc && in_operation == OpLoad;
        cmd.rel_clear  = acc && in_operation == OpTick;
        cmd.scan_clear = acc && in_operation == OpTick;
        cmd.done_tick  = acc && in_operation == OpTick && sts.done_now;
      end
      ST_REL:  cmd.rel_step = 1'b1;
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_RUN:  cmd.run = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> in_stall) else $error("accept while scanning");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_run_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> out_valid) else $error("run without result");

endmodule

FILE: rtl/edf_dp.sv
module edf_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_task_index,
  input  logic [15:0]       in_compute_time,
  input  logic [15:0]       in_relative_deadline,
  input  logic [15:0]       in_period,
  input  logic [15:0]       horizon,
  input  edf_pkg::edf_cmd_t cmd,
  output edf_pkg::edf_sts_t sts,
  output logic [15:0]       out_slot_time,
  output logic [3:0]        out_running_task,
  output logic              out_idle,
  output logic              out_done_res,
  output logic              out_job_overflow
);
  import edf_pkg::*;

  logic [15:0] time_r;
  logic        tvld_r [MaxTasks];
  logic [15:0] tcomp_r [MaxTasks];
  logic [15:0] tdl_r [MaxTasks];
  logic [15:0] tper_r [MaxTasks];
  logic [16:0] tnext_r [MaxTasks];

  logic        jvld_r [MaxJobs];
  logic [16:0] jdl_r [MaxJobs];
  logic [15:0] jrel_r [MaxJobs];
  logic [15:0] jrem_r [MaxJobs];
  logic [3:0]  jnum_r [MaxJobs];

  logic [TaskCntW-1:0] tcnt_r;
  logic [JobCntW-1:0]  jcnt_r;
  logic                best_ok_r;
  logic [JobIdxW-1:0]  best_r;
  logic                ovf_r;

  logic [TaskIdxW-1:0] ti;
  logic [JobIdxW-1:0]  ji;
  logic                free_ok;
  logic [JobIdxW-1:0]  free_j;
  logic                rel_hit;
  logic                better;

  assign ti = tcnt_r[TaskIdxW-1:0];
  assign ji = jcnt_r[JobIdxW-1:0];
  assign sts.rel_last  = (tcnt_r == TaskCntW'(MaxTasks - 1));
  assign sts.scan_last = (jcnt_r == JobCntW'(MaxJobs - 1));
  assign sts.done_now  = (time_r >= horizon);

  // first free job entry, lowest index has priority
  always_comb begin
    free_ok = 1'b0;
    free_j  = '0;
    for (int j = MaxJobs - 1; j >= 0; j--) begin
      if (!jvld_r[j]) begin
        free_ok = 1'b1;
        free_j  = JobIdxW'(j);
      end
    end
  end

  assign rel_hit = tvld_r[ti] && (tnext_r[ti] == {1'b0, time_r});

  always_comb begin
    better = 1'b0;
    if (!best_ok_r) better = 1'b1;
    else if (jdl_r[ji] != jdl_r[best_r]) better = jdl_r[ji] < jdl_r[best_r];
    else if (jrel_r[ji] != jrel_r[best_r]) better = jrel_r[ji] < jrel_r[best_r];
    else if (jrem_r[ji] != jrem_r[best_r]) better = jrem_r[ji] < jrem_r[best_r];
    else better = jnum_r[ji] < jnum_r[best_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      for (int t = 0; t < MaxTasks; t++) tvld_r[t] <= 1'b0;
      for (int j = 0; j < MaxJobs; j++) jvld_r[j] <= 1'b0;
      tcnt_r <= '0;
      jcnt_r <= '0;
      best_ok_r <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        tvld_r[in_task_index]  <= 1'b1;
        tcomp_r[in_task_index] <= in_compute_time;
        tdl_r[in_task_index]   <= in_relative_deadline;
        tper_r[in_task_index]  <= in_period;
        tnext_r[in_task_index] <= {1'b0, time_r};
      end
      if (cmd.rel_clear) begin
        tcnt_r <= '0;
        ovf_r  <= 1'b0;
      end
      if (cmd.scan_clear) begin
        jcnt_r    <= '0;
        best_ok_r <= 1'b0;
      end
      if (cmd.rel_step) begin
        tcnt_r <= tcnt_r + 1'b1;
        if (rel_hit) begin
          if (tcomp_r[ti] != '0) begin
            if (free_ok) begin
              jvld_r[free_j] <= 1'b1;
              jdl_r[free_j]  <= {1'b0, time_r} + {1'b0, tdl_r[ti]};
              jrel_r[free_j] <= time_r;
              jrem_r[free_j] <= tcomp_r[ti];
              jnum_r[free_j] <= TaskNumW'(ti) + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
          tnext_r[ti] <= (tper_r[ti] == '0) ? NeverRelease
                         : {1'b0, time_r} + {1'b0, tper_r[ti]};
        end
      end
      if (cmd.scan_step) begin
        jcnt_r <= jcnt_r + 1'b1;
        if (jvld_r[ji] && better) begin
          best_ok_r <= 1'b1;
          best_r    <= ji;
        end
      end
      if (cmd.run) begin
        out_slot_time    <= time_r;
        out_done_res     <= 1'b0;
        out_job_overflow <= ovf_r;
        out_idle         <= !best_ok_r;
        out_running_task <= best_ok_r ? jnum_r[best_r] : 4'd0;
        if (best_ok_r) begin
          jrem_r[best_r] <= jrem_r[best_r] - 1'b1;
          if (jrem_r[best_r] == 16'd1) jvld_r[best_r] <= 1'b0;
        end
        time_r <= time_r + 1'b1;
      end
      if (cmd.done_tick) begin
        out_slot_time    <= time_r;
        out_done_res     <= 1'b1;
        out_job_overflow <= 1'b0;
        out_idle         <= 1'b0;
        out_running_task <= 4'd0;
      end
    end
  end

  a_done_still: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done_tick |=> $stable(time_r)) else $error("time moved on done");
  a_run_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run |=> time_r == $past(time_r) + 16'd1) else $error("time not advanced");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rel_step, cmd.scan_step, cmd.run})) else $error("cmd clash");

endmodule
